### hdl/arprr_pkg.sv
// Shared types, constants and helper functions of the ARP request responder.
package arprr_pkg;

  // Configuration port shape and register indexes.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] CfgOwnMac = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOwnIp  = 1'b1;

  // Receive byte counter and the frame offsets it is compared against.
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] PosEthSrcFirst = 6'd6;
  localparam logic [CntW-1:0] PosEthSrcLast  = 6'd11;
  localparam logic [CntW-1:0] PosTypeHi      = 6'd12;
  localparam logic [CntW-1:0] PosTypeLo      = 6'd13;
  localparam logic [CntW-1:0] PosOpHi        = 6'd20;
  localparam logic [CntW-1:0] PosOpLo        = 6'd21;
  localparam logic [CntW-1:0] PosSndMacFirst = 6'd22;
  localparam logic [CntW-1:0] PosSndMacLast  = 6'd27;
  localparam logic [CntW-1:0] PosSndIpFirst  = 6'd28;
  localparam logic [CntW-1:0] PosSndIpLast   = 6'd31;
  localparam logic [CntW-1:0] PosTgtIpFirst  = 6'd38;
  localparam logic [CntW-1:0] PosTgtIpLast   = 6'd41;
  localparam logic [CntW-1:0] HeaderBytes    = 6'd42;

  // Protocol values that a request is matched against or a reply carries.
  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] ArpOpRequest = 16'h0001;
  localparam logic [15:0] ArpOpReply   = 16'h0002;
  localparam logic [15:0] ArpProtoIpv4 = 16'h0800;
  localparam logic [7:0]  ArpHwLen     = 8'd6;
  localparam logic [7:0]  ArpProtoLen  = 8'd4;

  // Shift commands from the reply sequencer to the capture registers.
  typedef struct packed {
    logic eth_src;
    logic tgt_ip;
    logic snd_mac;
    logic snd_ip;
  } shift_ctl_t;

  // Leading byte of each capture register, as seen by the reply sequencer.
  typedef struct packed {
    logic [7:0] eth_src;
    logic [7:0] tgt_ip;
    logic [7:0] snd_mac;
    logic [7:0] snd_ip;
  } hdr_tap_t;

  // Fixed bytes of the reply at offsets 12 to 21; zero elsewhere.
  function automatic logic [7:0] reply_const_byte(input int pos);
    logic [7:0] b;
    case (pos)
      12:      b = EtherTypeArp[15:8];
      13:      b = EtherTypeArp[7:0];
      14:      b = 8'h00;
      15:      b = 8'h01;
      16:      b = ArpProtoIpv4[15:8];
      17:      b = ArpProtoIpv4[7:0];
      18:      b = ArpHwLen;
      19:      b = ArpProtoLen;
      20:      b = ArpOpReply[15:8];
      21:      b = ArpOpReply[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/arprr_if.sv
// Valid/ready stream interfaces for received frame bytes and reply bytes.
interface arprr_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface arprr_reply_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;

  modport source (output valid, output reply_byte, output reply_last, input ready);
  modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

### hdl/arprr_capture.sv
// Receive side: byte counter, header capture shift registers and request match.
module arprr_capture
  import arprr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic [31:0] own_ip_i,
  input  shift_ctl_t  shift_i,
  output hdr_tap_t    tap_o,
  output logic        answer_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ok_q, ok_d;
  logic [47:0]     eth_src_q, snd_mac_q;
  logic [31:0]     snd_ip_q, tgt_ip_q;

  logic       in_eth_src, in_snd_mac, in_snd_ip, in_tgt_ip;
  logic [1:0] tgt_sel;
  logic [7:0] own_ip_byte;

  // Field windows by frame offset.
  assign in_eth_src = (cnt_q >= PosEthSrcFirst) && (cnt_q <= PosEthSrcLast);
  assign in_snd_mac = (cnt_q >= PosSndMacFirst) && (cnt_q <= PosSndMacLast);
  assign in_snd_ip  = (cnt_q >= PosSndIpFirst)  && (cnt_q <= PosSndIpLast);
  assign in_tgt_ip  = (cnt_q >= PosTgtIpFirst)  && (cnt_q <= PosTgtIpLast);

  // Byte of own_ip that lines up with the target IP byte now arriving.
  assign tgt_sel = 2'(cnt_q - PosTgtIpFirst);
  always_comb begin
    case (tgt_sel)
      2'd0:    own_ip_byte = own_ip_i[31:24];
      2'd1:    own_ip_byte = own_ip_i[23:16];
      2'd2:    own_ip_byte = own_ip_i[15:8];
      default: own_ip_byte = own_ip_i[7:0];
    endcase
  end

  // Running match of EtherType, opcode and target IP, one byte at a time.
  // It restarts on the first EtherType byte of every frame.
  always_comb begin
    ok_d = ok_q;
    if (in_fire_i) begin
      if (cnt_q == PosTypeHi) begin
        ok_d = (in_byte_i == EtherTypeArp[15:8]);
      end else if (cnt_q == PosTypeLo) begin
        ok_d = ok_q && (in_byte_i == EtherTypeArp[7:0]);
      end else if (cnt_q == PosOpHi) begin
        ok_d = ok_q && (in_byte_i == ArpOpRequest[15:8]);
      end else if (cnt_q == PosOpLo) begin
        ok_d = ok_q && (in_byte_i == ArpOpRequest[7:0]);
      end else if (in_tgt_ip) begin
        ok_d = ok_q && (in_byte_i == own_ip_byte);
      end
    end
  end

  // Byte counter saturates at the header length and clears after the last byte.
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire_i) begin
      if (in_last_i) begin
        cnt_d = '0;
      end else if (cnt_q < HeaderBytes) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // A reply is owed when the last byte closes a full header that matched.
  assign answer_o = in_fire_i && in_last_i && (cnt_q >= PosTgtIpLast) && ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ok_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ok_q  <= ok_d;
    end
  end

  // Capture registers shift bytes in while receiving and rotate bytes out
  // while the reply is sent.
  always_ff @(posedge clk_i) begin
    if (in_fire_i && in_eth_src) begin
      eth_src_q <= {eth_src_q[39:0], in_byte_i};
    end else if (shift_i.eth_src) begin
      eth_src_q <= {eth_src_q[39:0], eth_src_q[47:40]};
    end
    if (in_fire_i && in_snd_mac) begin
      snd_mac_q <= {snd_mac_q[39:0], in_byte_i};
    end else if (shift_i.snd_mac) begin
      snd_mac_q <= {snd_mac_q[39:0], snd_mac_q[47:40]};
    end
    if (in_fire_i && in_snd_ip) begin
      snd_ip_q <= {snd_ip_q[23:0], in_byte_i};
    end else if (shift_i.snd_ip) begin
      snd_ip_q <= {snd_ip_q[23:0], snd_ip_q[31:24]};
    end
    if (in_fire_i && in_tgt_ip) begin
      tgt_ip_q <= {tgt_ip_q[23:0], in_byte_i};
    end else if (shift_i.tgt_ip) begin
      tgt_ip_q <= {tgt_ip_q[23:0], tgt_ip_q[31:24]};
    end
  end

  assign tap_o.eth_src = eth_src_q[47:40];
  assign tap_o.snd_mac = snd_mac_q[47:40];
  assign tap_o.snd_ip  = snd_ip_q[31:24];
  assign tap_o.tgt_ip  = tgt_ip_q[31:24];

endmodule

### hdl/arprr_reply.sv
// Transmit side: byte-serial reply sequencer with a registered output stage.
module arprr_reply
  import arprr_pkg::*;
#(
  parameter int unsigned ReplyLength = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] own_mac_i,
  input  hdr_tap_t    tap_i,
  input  logic        out_ready_i,
  output shift_ctl_t  shift_o,
  output logic        busy_o,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  localparam int unsigned IdxW = $clog2(ReplyLength);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(ReplyLength - 1);

  typedef enum logic {
    StIdle,
    StSend
  } state_e;

  typedef enum logic [2:0] {
    SrcEthSrc,
    SrcOwnMac,
    SrcConst,
    SrcTgtIp,
    SrcSndMac,
    SrcSndIp,
    SrcZero
  } src_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic            ovalid_q;
  logic [7:0]      obyte_q;
  logic            olast_q;
  logic [47:0]     mac_q;

  logic       load;
  src_e       src;
  logic [7:0] next_byte;
  int         pos;

  assign pos  = int'(idx_q);
  assign load = (state_q == StSend) && (!ovalid_q || out_ready_i);

  // Reply layout: which source feeds each byte offset.
  always_comb begin
    if (pos < 6) begin
      src = SrcEthSrc;
    end else if (pos < 12) begin
      src = SrcOwnMac;
    end else if (pos < 22) begin
      src = SrcConst;
    end else if (pos < 28) begin
      src = SrcOwnMac;
    end else if (pos < 32) begin
      src = SrcTgtIp;
    end else if (pos < 38) begin
      src = SrcSndMac;
    end else if (pos < 42) begin
      src = SrcSndIp;
    end else begin
      src = SrcZero;
    end
  end

  always_comb begin
    unique case (src)
      SrcEthSrc: next_byte = tap_i.eth_src;
      SrcOwnMac: next_byte = mac_q[47:40];
      SrcConst:  next_byte = reply_const_byte(pos);
      SrcTgtIp:  next_byte = tap_i.tgt_ip;
      SrcSndMac: next_byte = tap_i.snd_mac;
      SrcSndIp:  next_byte = tap_i.snd_ip;
      default:   next_byte = 8'h00;
    endcase
  end

  // Each consumed byte rotates its source register to the next byte.
  assign shift_o.eth_src = load && (src == SrcEthSrc);
  assign shift_o.tgt_ip  = load && (src == SrcTgtIp);
  assign shift_o.snd_mac = load && (src == SrcSndMac);
  assign shift_o.snd_ip  = load && (src == SrcSndIp);

  assign busy_o = (state_q == StSend);

  // Sequencer state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StSend;
            idx_q   <= '0;
          end
        end
        StSend: begin
          if (load) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == IdxLast) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Output payload and the working copy of own MAC, used twice per reply.
  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= next_byte;
      olast_q <= (idx_q == IdxLast);
    end
    if (start_i) begin
      mac_q <= own_mac_i;
    end else if (load && (src == SrcOwnMac)) begin
      mac_q <= {mac_q[39:0], mac_q[47:40]};
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

### hdl/arp_request_responder_unit.sv
// Top level of the ARP request responder: configuration registers and datapath.
//
// Frame bytes are taken one per cycle while no reply is in progress. When the
// last byte of a frame closes a full 42-byte header carrying an ARP request
// for own_ip, the block answers with ReplyLength bytes, one per cycle as long
// as the sink takes them; the first reply byte is offered once the sequencer
// has entered its send state and loaded the output register. The byte-serial
// reply sequencer sets the cost: frame_in.ready stays low while the reply is
// sent, through any output stall, until the final reply byte enters the output
// register. Unanswered frames are taken one byte per cycle. own_mac and own_ip
// must be written by the user via the configuration port while idle; unchecked.
module arp_request_responder_unit
  import arprr_pkg::*;
#(
  parameter int unsigned ReplyLength = 56
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  arprr_frame_if.sink         frame_in,
  arprr_reply_if.source       reply_out,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic        in_fire;
  logic        answer;
  logic        busy;
  shift_ctl_t  shift;
  hdr_tap_t    tap;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgOwnMac: own_mac_q <= cfg_data_i[47:0];
        CfgOwnIp:  own_ip_q  <= cfg_data_i[31:0];
        default:   ;
      endcase
    end
  end

  // Input request handshake: held off while a reply is being sent.
  assign frame_in.ready = !busy;
  assign in_fire        = frame_in.valid && !busy;

  arprr_capture u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_byte_i (frame_in.frame_byte),
    .in_last_i (frame_in.frame_last),
    .own_ip_i  (own_ip_q),
    .shift_i   (shift),
    .tap_o     (tap),
    .answer_o  (answer)
  );

  arprr_reply #(
    .ReplyLength (ReplyLength)
  ) u_reply (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (answer),
    .own_mac_i   (own_mac_q),
    .tap_i       (tap),
    .out_ready_i (reply_out.ready),
    .shift_o     (shift),
    .busy_o      (busy),
    .out_valid_o (reply_out.valid),
    .out_byte_o  (reply_out.reply_byte),
    .out_last_o  (reply_out.reply_last)
  );

endmodule

### hdl/arprr_checker.sv
// Port-level assertions for the ARP request responder, bound to the top level.
module arprr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       frame_ready_i,
  input logic       reply_valid_i,
  input logic       reply_ready_i,
  input logic [7:0] reply_byte_i,
  input logic       reply_last_i
);

  // A stalled reply request keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && !reply_ready_i |=> reply_valid_i)
    else $error("reply valid dropped while stalled");

  // A stalled reply request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && !reply_ready_i |=> $stable(reply_byte_i) && $stable(reply_last_i))
    else $error("reply payload changed while stalled");

  // No frame byte is taken while a reply is still incomplete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && !reply_last_i |-> !frame_ready_i)
    else $error("frame accepted in the middle of a reply");

  // Reply bytes follow without gaps until the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_i && reply_ready_i && !reply_last_i |=> reply_valid_i)
    else $error("gap inside a reply");

endmodule

bind arp_request_responder_unit arprr_checker u_arprr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .frame_ready_i (frame_in.ready),
  .reply_valid_i (reply_out.valid),
  .reply_ready_i (reply_out.ready),
  .reply_byte_i  (reply_out.reply_byte),
  .reply_last_i  (reply_out.reply_last)
);
